### rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types, codes, tables and helpers shared by the piezo tone sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_CHIRP      = 3'd1,
    CMD_BUZZ       = 3'd2,
    CMD_MEL_LOCK   = 3'd3,
    CMD_MEL_UNLOCK = 3'd4,
    CMD_ALARM_ON   = 3'd5,
    CMD_ALARM_OFF  = 3'd6,
    CMD_MANUAL_PWM = 3'd7
  } cmd_t;

  // Melody kind
  typedef enum logic [1:0] {
    MEL_IDLE     = 2'd0,
    MEL_LOCKED   = 2'd1,
    MEL_UNLOCKED = 2'd2,
    MEL_SPARE    = 2'd3
  } mel_kind_t;

  // Tone codes
  localparam logic [3:0] TONE_SILENT     = 4'd0;
  localparam logic [3:0] TONE_RAW        = 4'd1;
  localparam logic [3:0] TONE_ALARM_BASE = 4'd2;
  localparam logic [3:0] TONE_CHIRP      = 4'd10;
  localparam logic [3:0] TONE_BUZZ       = 4'd11;
  localparam logic [3:0] TONE_DS7        = 4'd12;
  localparam logic [3:0] TONE_MID        = 4'd13;
  localparam logic [3:0] TONE_FS7        = 4'd14;

  // Register index
  localparam logic REG_VOLUME = 1'b0;
  localparam logic [1:0] VOLUME_RESET = 2'd3;

  // Timing and duty constants
  localparam logic [15:0] ALARM_STEP_MS = 16'd15;
  localparam logic [15:0] CHIRP_ON_MS   = 16'd75;
  localparam logic [15:0] BEEP_QUIET_MS = 16'd75;
  localparam logic [15:0] BUZZ_ON_MS    = 16'd100;
  localparam logic [6:0]  ALARM_DUTY    = 7'd50;
  localparam logic [6:0]  FIXED_DUTY    = 7'd10;
  localparam logic [7:0]  REST_MS       = 8'd50;

  // One accepted input item
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] elapsed_ms;
    logic [7:0]  repeat_count;
    logic        manual;
    logic [14:0] manual_period;
    logic [15:0] manual_on_time;
  } item_t;

  // One result item
  typedef struct packed {
    logic        pwm_write;
    logic [3:0]  tone_code;
    logic [6:0]  duty_pct;
    logic [14:0] raw_period;
    logic [15:0] raw_on_time;
    logic        output_on;
    logic        buzzer_idle;
  } result_t;

  // Melody note entry
  typedef struct packed {
    logic [3:0] tone;
    logic [7:0] dur;
    logic       scaled;
  } note_t;

  // Duty for the volume setting
  function automatic logic [6:0] level_duty(input logic [1:0] lvl);
    logic [6:0] d;
    case (lvl)
      2'd0:    d = 7'd5;
      2'd1:    d = 7'd10;
      2'd2:    d = 7'd25;
      default: d = 7'd10;
    endcase
    return d;
  endfunction

  // Melody tables; steps past the fourth note are 50 ms rests
  function automatic note_t melody_note(input logic unlocked, input logic [2:0] step);
    note_t n;
    logic [3:0] hi;
    logic [3:0] lo;
    hi = unlocked ? TONE_DS7 : TONE_FS7;
    lo = unlocked ? TONE_FS7 : TONE_DS7;
    case (step)
      3'd0:    n = '{tone: hi,       dur: 8'd85,  scaled: 1'b1};
      3'd1:    n = '{tone: hi,       dur: 8'd25,  scaled: 1'b1};
      3'd2:    n = '{tone: TONE_MID, dur: 8'd135, scaled: 1'b1};
      3'd3:    n = '{tone: lo,       dur: 8'd85,  scaled: 1'b0};
      default: n = '{tone: TONE_SILENT, dur: REST_MS, scaled: 1'b0};
    endcase
    return n;
  endfunction

  // Saturating 16-bit add
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/pts_cfg_regs.sv
// ----------------------------------------------------------------------------
// pts_cfg_regs
// APB-style register port holding the volume level.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_cfg_regs
  import pts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [1:0]       volume
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_VOLUME);

  // Volume register
  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
    end else if (wr_en) begin
      volume <= pwdata[1:0];
    end
  end

  // Read back; unused bits and addresses read zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VOLUME) begin
      prdata[1:0] = volume;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pts_seq_core.sv
// ----------------------------------------------------------------------------
// pts_seq_core
// Sequencer state and the single-pass update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_seq_core
  import pts_pkg::*;
#(
  parameter int ALARM_STEPS  = 8,
  parameter int MELODY_STEPS = 5
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step_en,
  input  wire item_t      item,
  input  wire logic [1:0] volume,
  output result_t         res
);

  localparam logic [2:0] ALARM_LAST = 3'(ALARM_STEPS - 1);
  localparam logic [3:0] MEL_LEN    = 4'(MELODY_STEPS);

  // State
  logic [3:0]  chirps_pending, buzzes_pending, melody_repeats;
  mel_kind_t   melody_kind;
  logic        alarm_on, alarm_lock, pwm_forced, pwm_enabled, beep_sounding;
  logic [2:0]  step_index;
  logic [15:0] note_timer, beep_start_timer, beep_stop_timer;

  logic [3:0]  chirps_pending_next, buzzes_pending_next, melody_repeats_next;
  mel_kind_t   melody_kind_next;
  logic        alarm_on_next, alarm_lock_next, pwm_forced_next;
  logic        pwm_enabled_next, beep_sounding_next;
  logic [2:0]  step_index_next;
  logic [15:0] note_timer_next, beep_start_timer_next, beep_stop_timer_next;

  // Scratch
  logic [15:0] nt, bst, bsp;
  logic [3:0]  beep_cnt;
  logic [3:0]  beep_tone;
  logic [15:0] beep_on_ms;
  logic        use_chirp;
  logic        unlocked;
  note_t       cur_note, nxt_note, first_note;
  logic [2:0]  cur_step;
  logic [3:0]  step_inc;
  logic [2:0]  mel_next;
  logic [6:0]  vol_duty;

  always_comb begin
    chirps_pending_next   = chirps_pending;
    buzzes_pending_next   = buzzes_pending;
    melody_repeats_next   = melody_repeats;
    melody_kind_next      = melody_kind;
    alarm_on_next         = alarm_on;
    alarm_lock_next       = alarm_lock;
    pwm_forced_next       = pwm_forced;
    pwm_enabled_next      = pwm_enabled;
    beep_sounding_next    = beep_sounding;
    step_index_next       = step_index;
    note_timer_next       = note_timer;
    beep_start_timer_next = beep_start_timer;
    beep_stop_timer_next  = beep_stop_timer;
    res                   = '0;

    nt  = sat_add(note_timer, item.elapsed_ms);
    bst = sat_add(beep_start_timer, item.elapsed_ms);
    bsp = sat_add(beep_stop_timer, item.elapsed_ms);

    vol_duty   = level_duty(volume);
    use_chirp  = (chirps_pending != 4'd0);
    beep_cnt   = use_chirp ? chirps_pending : buzzes_pending;
    beep_tone  = use_chirp ? TONE_CHIRP : TONE_BUZZ;
    beep_on_ms = use_chirp ? CHIRP_ON_MS : BUZZ_ON_MS;

    // Melody step lookup; a stale index reads as a rest
    unlocked   = (melody_kind == MEL_UNLOCKED);
    cur_step   = ({1'b0, step_index} < MEL_LEN) ? step_index : 3'd7;
    cur_note   = melody_note(unlocked, cur_step);
    step_inc   = {1'b0, step_index} + 4'd1;
    mel_next   = (step_inc >= MEL_LEN) ? 3'd0 : step_inc[2:0];
    nxt_note   = melody_note(unlocked, mel_next);
    first_note = melody_note(unlocked, 3'd0);

    case (item.cmd)
      CMD_TICK: begin
        if (!pwm_forced) begin
          note_timer_next       = nt;
          beep_start_timer_next = bst;
          beep_stop_timer_next  = bsp;
          if (alarm_on) begin
            // Alarm sweep overrides everything queued
            chirps_pending_next = 4'd0;
            buzzes_pending_next = 4'd0;
            melody_repeats_next = 4'd0;
            melody_kind_next    = MEL_IDLE;
            if (nt >= ALARM_STEP_MS) begin
              step_index_next  = (step_index < ALARM_LAST) ? step_index + 3'd1 : 3'd0;
              res.pwm_write    = 1'b1;
              res.tone_code    = TONE_ALARM_BASE + {1'b0, step_index_next};
              res.duty_pct     = ALARM_DUTY;
              pwm_enabled_next = 1'b1;
              note_timer_next  = '0;
            end
          end else if (chirps_pending != 4'd0 || buzzes_pending != 4'd0) begin
            // Chirp or buzz: on phase then quiet phase
            if (!beep_sounding) begin
              if (bsp >= BEEP_QUIET_MS) begin
                res.pwm_write         = 1'b1;
                res.tone_code         = beep_tone;
                res.duty_pct          = vol_duty;
                pwm_enabled_next      = 1'b1;
                beep_start_timer_next = '0;
                beep_sounding_next    = 1'b1;
              end
            end else if (bst >= beep_on_ms) begin
              res.pwm_write        = 1'b1;
              pwm_enabled_next     = 1'b0;
              beep_stop_timer_next = '0;
              beep_sounding_next   = 1'b0;
              if (use_chirp) begin
                chirps_pending_next = beep_cnt - 4'd1;
              end else begin
                buzzes_pending_next = beep_cnt - 4'd1;
              end
            end
          end else if (melody_repeats != 4'd0 && melody_kind != MEL_IDLE) begin
            if (!pwm_enabled) begin
              // First note of a melody
              step_index_next  = '0;
              pwm_enabled_next = 1'b1;
              note_timer_next  = '0;
              res.pwm_write    = 1'b1;
              res.tone_code    = first_note.tone;
              res.duty_pct     = vol_duty;
            end else if (nt >= {8'd0, cur_note.dur}) begin
              step_index_next = mel_next;
              if (step_inc >= MEL_LEN) begin
                if (melody_repeats > 4'd1) begin
                  melody_repeats_next = melody_repeats - 4'd1;
                end else begin
                  melody_repeats_next = 4'd0;
                  res.pwm_write       = 1'b1;
                  pwm_enabled_next    = 1'b0;
                  melody_kind_next    = MEL_IDLE;
                end
              end
              if (melody_repeats_next != 4'd0) begin
                res.pwm_write    = 1'b1;
                res.tone_code    = nxt_note.tone;
                res.duty_pct     = (nxt_note.tone == TONE_SILENT) ? 7'd0 :
                                   (nxt_note.scaled ? vol_duty : FIXED_DUTY);
                pwm_enabled_next = 1'b1;
                note_timer_next  = '0;
              end
            end
          end else begin
            // Nothing due: write silence
            res.pwm_write    = 1'b1;
            pwm_enabled_next = 1'b0;
          end
        end
      end
      CMD_CHIRP: begin
        chirps_pending_next = chirps_pending + item.repeat_count[3:0];
      end
      CMD_BUZZ: begin
        buzzes_pending_next = buzzes_pending + item.repeat_count[3:0];
      end
      CMD_MEL_LOCK, CMD_MEL_UNLOCK: begin
        if (melody_kind == MEL_IDLE) begin
          melody_kind_next    = (item.cmd == CMD_MEL_LOCK) ? MEL_LOCKED : MEL_UNLOCKED;
          melody_repeats_next = melody_repeats + item.repeat_count[3:0];
        end
      end
      CMD_ALARM_ON, CMD_ALARM_OFF: begin
        if (item.manual) begin
          alarm_on_next   = (item.cmd == CMD_ALARM_ON);
          alarm_lock_next = (item.cmd == CMD_ALARM_ON);
        end else if (!alarm_lock) begin
          alarm_on_next = (item.cmd == CMD_ALARM_ON);
        end
      end
      CMD_MANUAL_PWM: begin
        res.pwm_write   = 1'b1;
        res.tone_code   = TONE_RAW;
        res.raw_period  = item.manual_period;
        res.raw_on_time = item.manual_on_time;
        if (item.manual_period == '0 || item.manual_on_time == '0) begin
          pwm_forced_next  = 1'b0;
          pwm_enabled_next = 1'b0;
        end else begin
          pwm_forced_next  = 1'b1;
          pwm_enabled_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.output_on   = pwm_enabled_next;
    res.buzzer_idle = (chirps_pending_next == 4'd0) && !alarm_on_next && !pwm_enabled_next &&
                      (buzzes_pending_next == 4'd0) && (melody_repeats_next == 4'd0);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chirps_pending   <= '0;
      buzzes_pending   <= '0;
      melody_repeats   <= '0;
      melody_kind      <= MEL_IDLE;
      alarm_on         <= 1'b0;
      alarm_lock       <= 1'b0;
      pwm_forced       <= 1'b0;
      pwm_enabled      <= 1'b0;
      beep_sounding    <= 1'b0;
      step_index       <= '0;
      note_timer       <= '0;
      beep_start_timer <= '0;
      beep_stop_timer  <= '0;
    end else if (step_en) begin
      chirps_pending   <= chirps_pending_next;
      buzzes_pending   <= buzzes_pending_next;
      melody_repeats   <= melody_repeats_next;
      melody_kind      <= melody_kind_next;
      alarm_on         <= alarm_on_next;
      alarm_lock       <= alarm_lock_next;
      pwm_forced       <= pwm_forced_next;
      pwm_enabled      <= pwm_enabled_next;
      beep_sounding    <= beep_sounding_next;
      step_index       <= step_index_next;
      note_timer       <= note_timer_next;
      beep_start_timer <= beep_start_timer_next;
      beep_stop_timer  <= beep_stop_timer_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/piezo_tone_sequencer_core.sv
// Path: an accepted item is held in the input register, then its result in
//   the result register; a stalled output can hold the item in between.
// Throughput: one item per cycle while the output is not stalled; the state
//   update is a single combinational pass between input and result registers.
// Reset: synchronous, active high; clears all sequencer state, both valid
//   flags, and sets the volume level to 3.
// ----------------------------------------------------------------------------
// piezo_tone_sequencer_core
// Buzzer sequencer: chirps, buzzes, melodies, alarm sweep and raw PWM override.
// ----------------------------------------------------------------------------
`default_nettype none

module piezo_tone_sequencer_core
  import pts_pkg::*;
#(
  parameter int ALARM_STEPS  = 8,
  parameter int MELODY_STEPS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [15:0] elapsed_ms,
  input  wire logic [7:0]  repeat_count,
  input  wire logic        manual,
  input  wire logic [14:0] manual_period,
  input  wire logic [15:0] manual_on_time,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             pwm_write,
  output logic [3:0]       tone_code,
  output logic [6:0]       duty_pct,
  output logic [14:0]      raw_period,
  output logic [15:0]      raw_on_time,
  output logic             output_on,
  output logic             buzzer_idle
);

  logic       s1_valid;
  item_t      s1_item;
  logic       s1_adv;
  logic       in_take;
  logic [1:0] volume;
  result_t    res_comb;
  result_t    res_q;

  // Handshake
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  pts_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .volume  (volume)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= '{cmd: cmd_t'(cmd), elapsed_ms: elapsed_ms, repeat_count: repeat_count,
                   manual: manual, manual_period: manual_period,
                   manual_on_time: manual_on_time};
    end
  end

  pts_seq_core #(
    .ALARM_STEPS  (ALARM_STEPS),
    .MELODY_STEPS (MELODY_STEPS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (s1_adv),
    .item    (s1_item),
    .volume  (volume),
    .res     (res_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_q <= res_comb;
    end
  end

  assign pwm_write   = res_q.pwm_write;
  assign tone_code   = res_q.tone_code;
  assign duty_pct    = res_q.duty_pct;
  assign raw_period  = res_q.raw_period;
  assign raw_on_time = res_q.raw_on_time;
  assign output_on   = res_q.output_on;
  assign buzzer_idle = res_q.buzzer_idle;

  // Checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result path free");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted item lost from input register");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result repeated after delivery");

endmodule

`default_nettype wire
